>>> hdl/assert_macros.svh
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/spe_pkg.sv
package spe_pkg;

  localparam logic [12:0] SPE_MAX_POS = 13'd4096;
  localparam logic [10:0] SPE_MAX_DIM = 11'd1024;

  localparam logic [3:0] SPE_CFG_MODEL_WIDTH = 4'd0;
  localparam logic [3:0] SPE_CFG_MAX_POS     = 4'd1;

  localparam logic [10:0] SPE_MW_RST = 11'd512;
  localparam logic [12:0] SPE_MP_RST = 13'd4096;

  // log2(10000) in Q24
  localparam logic [27:0] SPE_LOG2_TENK = 28'd222930821;

  localparam logic [29:0] SPE_TWO_PI_U = 30'd411775;
  localparam logic [19:0] SPE_HALF_PI_U = 20'd102944;

  typedef logic signed [19:0] spe_ang_t;
  typedef logic signed [32:0] spe_vec_t;

  localparam spe_ang_t SPE_PI      = 20'sd205887;
  localparam spe_ang_t SPE_HALF_PI = 20'sd102944;
  localparam spe_ang_t SPE_TWO_PI  = 20'sd411775;

  localparam spe_vec_t SPE_CORDIC_X0 = 33'sd652032874;
  localparam int       SPE_CORDIC_N  = 16;

  localparam logic [15:0] SPE_ATAN [SPE_CORDIC_N] = '{
    16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
  };

  typedef struct packed {
    logic        vld;
    logic        inv;
    logic        odd;
    logic [11:0] pos;
  } spe_tag_t;

  function automatic logic [63:0] spe_isqrt(logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = n;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-b) in Q30
  function automatic logic [29:0] spe_exp_coef(int b);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int i = 1; i <= 24; i++) begin
      if (i <= b) begin
        c = spe_isqrt(c << 30);
      end
    end
    return c[29:0];
  endfunction

  // one restoring step of the reduction modulo 2*pi
  function automatic logic [29:0] spe_mod_step(logic [29:0] x, int k);
    logic [29:0] d;
    d = SPE_TWO_PI_U << k;
    if (x >= d) begin
      return x - d;
    end
    return x;
  endfunction

endpackage

>>> hdl/spe_div.sv
module spe_div
  import spe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  spe_tag_t    tag_i,
  input  logic [37:0] dvd_i,
  input  logic [10:0] mw_i,
  output spe_tag_t    tag_o,
  output logic [27:0] quo_o
);

  localparam int BPS = 4;
  localparam int NS  = 28 / BPS;

  spe_tag_t    tag_in  [NS];
  logic [10:0] rem_in  [NS];
  logic [27:0] lo_in   [NS];
  logic [27:0] q_in    [NS];
  logic [10:0] rem_nxt [NS];
  logic [27:0] lo_nxt  [NS];
  logic [27:0] q_nxt   [NS];
  spe_tag_t    tag_r   [NS];
  logic [10:0] rem_r   [NS];
  logic [27:0] lo_r    [NS];
  logic [27:0] q_r     [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stg
    if (g == 0) begin : g_first
      assign tag_in[g] = tag_i;
      assign rem_in[g] = {1'b0, dvd_i[37:28]};
      assign lo_in[g]  = dvd_i[27:0];
      assign q_in[g]   = '0;
    end else begin : g_next
      assign tag_in[g] = tag_r[g-1];
      assign rem_in[g] = rem_r[g-1];
      assign lo_in[g]  = lo_r[g-1];
      assign q_in[g]   = q_r[g-1];
    end

    always_comb begin
      logic [11:0] trial;
      logic [10:0] rem;
      logic [27:0] lo;
      logic [27:0] q;
      rem = rem_in[g];
      lo  = lo_in[g];
      q   = q_in[g];
      for (int j = 0; j < BPS; j++) begin
        trial = {rem, lo[27]};
        lo    = {lo[26:0], 1'b0};
        if (trial >= {1'b0, mw_i}) begin
          rem = 11'(trial - {1'b0, mw_i});
          q   = {q[26:0], 1'b1};
        end else begin
          rem = trial[10:0];
          q   = {q[26:0], 1'b0};
        end
      end
      rem_nxt[g] = rem;
      lo_nxt[g]  = lo;
      q_nxt[g]   = q;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[g] <= '0;
      end else if (en) begin
        tag_r[g] <= tag_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt[g];
        lo_r[g]  <= lo_nxt[g];
        q_r[g]   <= q_nxt[g];
      end
    end
  end

  assign tag_o = tag_r[NS-1];
  assign quo_o = q_r[NS-1];

endmodule

>>> hdl/spe_exp2.sv
module spe_exp2
  import spe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  spe_tag_t    tag_i,
  input  logic [27:0] t_i,
  output spe_tag_t    tag_o,
  output logic [3:0]  u_o,
  output logic [30:0] m_o
);

  localparam int NS = 24;

  spe_tag_t    tag_in   [NS];
  logic [3:0]  u_in     [NS];
  logic [30:0] m_in     [NS];
  logic [23:0] frac_in  [NS];
  logic [30:0] m_nxt    [NS];
  spe_tag_t    tag_r    [NS];
  logic [3:0]  u_r      [NS];
  logic [30:0] m_r      [NS];
  logic [23:0] frac_r   [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stg
    localparam logic [29:0] COEF = spe_exp_coef(g + 1);

    if (g == 0) begin : g_first
      assign tag_in[g]  = tag_i;
      assign u_in[g]    = t_i[27:24];
      assign m_in[g]    = 31'h4000_0000;
      assign frac_in[g] = t_i[23:0];
    end else begin : g_next
      assign tag_in[g]  = tag_r[g-1];
      assign u_in[g]    = u_r[g-1];
      assign m_in[g]    = m_r[g-1];
      assign frac_in[g] = frac_r[g-1];
    end

    always_comb begin
      logic [60:0] prod;
      prod = 61'(m_in[g]) * 61'(COEF);
      if (frac_in[g][23]) begin
        m_nxt[g] = prod[60:30];
      end else begin
        m_nxt[g] = m_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[g] <= '0;
      end else if (en) begin
        tag_r[g] <= tag_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        u_r[g]    <= u_in[g];
        m_r[g]    <= m_nxt[g];
        frac_r[g] <= {frac_in[g][22:0], 1'b0};
      end
    end
  end

  assign tag_o = tag_r[NS-1];
  assign u_o   = u_r[NS-1];
  assign m_o   = m_r[NS-1];

endmodule

>>> hdl/spe_angle.sv
module spe_angle
  import spe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  spe_tag_t    tag_i,
  input  logic [3:0]  u_i,
  input  logic [30:0] m_i,
  output spe_tag_t    tag_o,
  output spe_ang_t    z_o
);

  spe_tag_t    tag1_r, tag2_r, tag3_r, tag4_r;
  logic [42:0] prod_r;
  logic [3:0]  u1_r;
  logic [23:0] x2_r;
  logic [18:0] r3_r;
  spe_ang_t    z4_r;
  logic [23:0] x2_nxt;
  logic [18:0] r3_nxt;
  spe_ang_t    z4_nxt;

  // coarse reduction, quotient bits 10 down to 5
  always_comb begin
    logic [42:0] sh;
    logic [29:0] x;
    sh = prod_r >> (6'd14 + {2'b00, u1_r});
    x  = sh[29:0];
    for (int k = 10; k >= 5; k--) begin
      x = spe_mod_step(x, k);
    end
    x2_nxt = x[23:0];
  end

  // fine reduction, quotient bits 4 down to 0
  always_comb begin
    logic [29:0] x;
    x = {6'd0, x2_r};
    for (int k = 4; k >= 0; k--) begin
      x = spe_mod_step(x, k);
    end
    r3_nxt = x[18:0];
  end

  // cosine phase shift and fold into [-pi/2, pi/2]
  always_comb begin
    logic [19:0] s;
    spe_ang_t    z;
    s = {1'b0, r3_r} + (tag3_r.odd ? SPE_HALF_PI_U : 20'd0);
    if (s >= SPE_TWO_PI_U[19:0]) begin
      s = s - SPE_TWO_PI_U[19:0];
    end
    z = $signed(s);
    if (z > SPE_PI) begin
      z = z - SPE_TWO_PI;
    end
    if (z > SPE_HALF_PI) begin
      z = SPE_PI - z;
    end else if (z < -SPE_HALF_PI) begin
      z = -SPE_PI - z;
    end
    z4_nxt = z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else if (en) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 43'(tag_i.pos) * 43'(m_i);
      u1_r   <= u_i;
      x2_r   <= x2_nxt;
      r3_r   <= r3_nxt;
      z4_r   <= z4_nxt;
    end
  end

  assign tag_o = tag4_r;
  assign z_o   = z4_r;

endmodule

>>> hdl/spe_cordic.sv
module spe_cordic
  import spe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  spe_tag_t    tag_i,
  input  spe_ang_t    z_i,
  output spe_tag_t    tag_o,
  output logic [15:0] val_o
);

  localparam int NS = SPE_CORDIC_N;

  spe_tag_t tag_in [NS];
  spe_vec_t x_in   [NS];
  spe_vec_t y_in   [NS];
  spe_ang_t z_in   [NS];
  spe_vec_t x_nxt  [NS];
  spe_vec_t y_nxt  [NS];
  spe_ang_t z_nxt  [NS];
  spe_tag_t tag_r  [NS];
  spe_vec_t x_r    [NS];
  spe_vec_t y_r    [NS];
  spe_ang_t z_r    [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stg
    localparam spe_ang_t ATAN = $signed({4'd0, SPE_ATAN[g]});

    if (g == 0) begin : g_first
      assign tag_in[g] = tag_i;
      assign x_in[g]   = SPE_CORDIC_X0;
      assign y_in[g]   = '0;
      assign z_in[g]   = z_i;
    end else begin : g_next
      assign tag_in[g] = tag_r[g-1];
      assign x_in[g]   = x_r[g-1];
      assign y_in[g]   = y_r[g-1];
      assign z_in[g]   = z_r[g-1];
    end

    always_comb begin
      spe_vec_t dx;
      spe_vec_t dy;
      dx = y_in[g] >>> g;
      dy = x_in[g] >>> g;
      if (z_in[g] >= 0) begin
        x_nxt[g] = x_in[g] - dx;
        y_nxt[g] = y_in[g] + dy;
        z_nxt[g] = z_in[g] - ATAN;
      end else begin
        x_nxt[g] = x_in[g] + dx;
        y_nxt[g] = y_in[g] - dy;
        z_nxt[g] = z_in[g] + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[g] <= '0;
      end else if (en) begin
        tag_r[g] <= tag_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g] <= x_nxt[g];
        y_r[g] <= y_nxt[g];
        z_r[g] <= z_nxt[g];
      end
    end
  end

  // round to Q1.15 and saturate; an invalid entry gives zero
  always_comb begin
    spe_vec_t v;
    v = (y_r[NS-1] + 33'sd16384) >>> 15;
    if (tag_r[NS-1].inv) begin
      val_o = '0;
    end else if (v > 33'sd32767) begin
      val_o = 16'h7fff;
    end else if (v < -33'sd32768) begin
      val_o = 16'h8000;
    end else begin
      val_o = v[15:0];
    end
  end

  assign tag_o = tag_r[NS-1];

endmodule

>>> hdl/sinusoidal_position_encoder_unit.sv
// Sinusoidal position encoding generator, one table entry per transaction.
// Input stream: in_tdata carries position and dimension index; each accepted
// transaction yields exactly one result on the output stream, in order.
// Output stream: out_tdata is the Q1.15 value, out_tuser the status flag
// (set for a position or index out of range, value then zero).
// Configuration: cfg_index 0 writes model_width, 1 writes max_positions,
// other indexes are ignored; cfg_ready is always high. Write only while idle.
// Pipeline: the input register, the 7-stage divider, the 24 conditional
// multiplies of the power-of-two stage, four angle stages, 16 CORDIC stages
// and the output register lie between acceptance and out_tvalid.
// Throughput: one transaction per cycle while in_tready is high.
// Reset: rst_n low clears all valid bits and returns model_width to 512 and
// max_positions to 4096. The block keeps no other state.
// Stall: a two-entry output buffer holds results; when both entries are full
// in_tready drops and the whole pipeline holds until out_tready returns.
module sinusoidal_position_encoder_unit
  import spe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [11:0] position, [21:12] dim_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] enc_value
  output logic        out_tuser,  // [0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  `include "assert_macros.svh"

  logic [10:0] mw_r;
  logic [12:0] mp_r;
  logic        en;
  logic [11:0] pos;
  logic [9:0]  idx;
  logic        inv;
  spe_tag_t    tag0_r;
  logic [37:0] dvd_r;
  spe_tag_t    tag_div, tag_exp, tag_ang, tag_cor;
  logic [27:0] quo;
  logic [3:0]  u;
  logic [30:0] m;
  spe_ang_t    z;
  logic [15:0] val;
  logic        out_vld_r, skd_vld_r;
  logic [15:0] out_val_r, skd_val_r;
  logic        out_sts_r, skd_sts_r;
  logic        take, arrive;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mw_r <= SPE_MW_RST;
      mp_r <= SPE_MP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        SPE_CFG_MODEL_WIDTH: mw_r <= cfg_data[10:0];
        SPE_CFG_MAX_POS:     mp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = ~skd_vld_r;
  assign in_tready = en;

  assign pos = in_tdata[11:0];
  assign idx = in_tdata[21:12];
  assign inv = (mw_r == 11'd0) || (mw_r > SPE_MAX_DIM) || ({1'b0, idx} >= mw_r) ||
               ({1'b0, pos} >= mp_r) || ({1'b0, pos} >= SPE_MAX_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= '0;
    end else if (en) begin
      tag0_r.vld <= in_tvalid;
      tag0_r.inv <= inv;
      tag0_r.odd <= idx[0];
      tag0_r.pos <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r <= 38'({idx[9:1], 1'b0}) * 38'(SPE_LOG2_TENK);
    end
  end

  spe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (tag0_r),
    .dvd_i (dvd_r),
    .mw_i  (mw_r),
    .tag_o (tag_div),
    .quo_o (quo)
  );

  spe_exp2 u_exp2 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (tag_div),
    .t_i   (quo),
    .tag_o (tag_exp),
    .u_o   (u),
    .m_o   (m)
  );

  spe_angle u_angle (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (tag_exp),
    .u_i   (u),
    .m_i   (m),
    .tag_o (tag_ang),
    .z_o   (z)
  );

  spe_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (tag_ang),
    .z_i   (z),
    .tag_o (tag_cor),
    .val_o (val)
  );

  assign take   = out_vld_r & out_tready;
  assign arrive = en & tag_cor.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skd_vld_r <= 1'b0;
    end else if (!out_vld_r || take) begin
      out_vld_r <= skd_vld_r | arrive;
      skd_vld_r <= 1'b0;
    end else if (arrive) begin
      skd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || take) begin
      if (skd_vld_r) begin
        out_val_r <= skd_val_r;
        out_sts_r <= skd_sts_r;
      end else begin
        out_val_r <= val;
        out_sts_r <= tag_cor.inv;
      end
    end else if (arrive) begin
      skd_val_r <= val;
      skd_sts_r <= tag_cor.inv;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_sts_r;

  `SPE_ASSERT(a_skid_behind_out, skd_vld_r, out_vld_r, "skid entry without output entry")
  `SPE_ASSERT(a_inv_zero, out_vld_r && out_sts_r, out_val_r == 16'd0,
              "invalid result with nonzero value")
  `SPE_ASSERT(a_skid_fill, skd_vld_r && !$past(skd_vld_r),
              $past(out_vld_r && !out_tready), "skid filled while output moved")
  `SPE_ASSERT_NEXT(a_skid_drain, take && skd_vld_r, out_vld_r && !skd_vld_r,
                   "skid entry not moved to output")

endmodule

>>> bench/sinusoidal_position_encoder_unit_test.sv
module sinusoidal_position_encoder_unit_test;
  import spe_pkg::*;

  localparam logic [3:0] CFG_UNUSED_INDEX = 4'd9;
  localparam longint LOG2_TENK = 222930821;
  localparam longint TWO_PI = 411775;
  localparam longint PI = 205887;
  localparam longint HALF_PI = 102944;
  localparam longint GAIN = 652032874;
  localparam int PIPE_DRAIN = 70;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [15:0] enc_value;
    logic        status;
  } enc_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  logic [10:0] width_reg;
  logic [12:0] limit_reg;
  longint unsigned half_pow_coef [1:24];
  longint atan_tab [16];
  enc_entry_t pending_entries [$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 1'b0;

  sinusoidal_position_encoder_unit DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= no_idle || ($urandom_range(99) >= 33);

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic enc_entry_t predict_entry(logic [11:0] pos, logic [9:0] idx);
    enc_entry_t e;
    longint unsigned t, m;
    int u;
    longint ang, x, y, z, dx, dy, v;
    e.enc_value = '0;
    e.status = 1'b1;
    if (width_reg == 0 || width_reg > SPE_MAX_DIM || idx >= width_reg || pos >= limit_reg)
      return e;
    t = (longint'(idx & 10'h3FE) * LOG2_TENK) / width_reg;
    u = int'(t >> 24);
    m = 64'd1 << 30;
    for (int b = 1; b <= 24; b++)
      if (t[24 - b]) m = (m * half_pow_coef[b]) >> 30;
    ang = longint'((longint'(pos) * m) >> (14 + u)) % TWO_PI;
    if (idx[0]) ang = (ang + HALF_PI) % TWO_PI;
    z = ang;
    if (z > PI) z = z - TWO_PI;
    if (z > HALF_PI) z = PI - z;
    else if (z < -HALF_PI) z = -PI - z;
    x = GAIN;
    y = 0;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_tab[k];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[k];
      end
    end
    v = (y + (64'sd1 << 14)) >>> 15;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    e.enc_value = v[15:0];
    e.status = 1'b0;
    return e;
  endfunction

  always @(posedge clk) begin
    enc_entry_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_entries.size() == 0) begin
        $display("%0t unexpected transaction: actual value %0d status %0b",
                 $time, $signed(out_tdata), out_tuser);
        errors++;
      end else begin
        want = pending_entries.pop_front();
        if (out_tdata !== want.enc_value || out_tuser !== want.status) begin
          $display("%0t mismatch: expected value %0d status %0b, actual value %0d status %0b",
                   $time, $signed(want.enc_value), want.status, $signed(out_tdata), out_tuser);
          errors++;
        end
      end
    end
  end

  task automatic send_entry(logic [11:0] pos, logic [9:0] idx);
    if (!no_idle) begin
      while ($urandom_range(99) < 33) begin
        @(negedge clk);
        in_tvalid = 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {2'b00, idx, pos};
    do @(posedge clk); while (!in_tready);
    pending_entries.push_back(predict_entry(pos, idx));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] index, logic [12:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    if (index == SPE_CFG_MODEL_WIDTH) width_reg = value[10:0];
    else if (index == SPE_CFG_MAX_POS) limit_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_entry(12'd0, 10'd0);
    send_entry(12'd0, 10'd1);
    send_entry(12'd4095, 10'd511);
    send_entry(12'd4095, 10'd510);
    send_entry(12'd1, 10'd0);
    send_entry(12'd1, 10'd1);
    send_entry(12'd100, 10'd2);
    send_entry(12'd2047, 10'd255);
    send_entry(12'd10, 10'd512);
    send_entry(12'd3000, 10'd1023);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(SPE_CFG_MODEL_WIDTH, 13'd1024);
    write_reg(SPE_CFG_MAX_POS, 13'd8191);
    send_entry(12'd4095, 10'd1023);
    send_entry(12'd4095, 10'd1022);
    send_entry(12'd7, 10'd0);
    wait_idle();
    write_reg(SPE_CFG_MODEL_WIDTH, 13'd1);
    write_reg(SPE_CFG_MAX_POS, 13'd1);
    send_entry(12'd0, 10'd0);
    send_entry(12'd1, 10'd0);
    send_entry(12'd0, 10'd1);
    wait_idle();
    write_reg(SPE_CFG_MAX_POS, 13'd0);
    send_entry(12'd0, 10'd0);
    wait_idle();
    write_reg(SPE_CFG_MODEL_WIDTH, 13'd0);
    write_reg(SPE_CFG_MAX_POS, 13'd4096);
    send_entry(12'd5, 10'd0);
    wait_idle();
    // width beyond the maximum, and upper data bits dropped
    write_reg(SPE_CFG_MODEL_WIDTH, 13'd2047);
    send_entry(12'd5, 10'd3);
    wait_idle();
    write_reg(SPE_CFG_MODEL_WIDTH, 13'h1802);
    write_reg(CFG_UNUSED_INDEX, 13'd3);
    send_entry(12'd4000, 10'd1);
    send_entry(12'd4000, 10'd2);
    wait_idle();
  endtask

  task automatic run_random_phase(logic [12:0] mw, logic [12:0] mp, int count);
    logic [11:0] pos;
    logic [9:0] idx;
    write_reg(SPE_CFG_MODEL_WIDTH, mw);
    write_reg(SPE_CFG_MAX_POS, mp);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 8 && width_reg >= 1 && width_reg <= SPE_MAX_DIM && limit_reg != 0) begin
        pos = (limit_reg > 4096) ? 12'($urandom) : 12'($urandom_range(limit_reg - 1));
        idx = 10'($urandom_range(width_reg - 1));
      end else begin
        pos = 12'($urandom);
        idx = 10'($urandom);
      end
      send_entry(pos, idx);
    end
    wait_idle();
  endtask

  task automatic test_random_entries();
    run_random_phase(13'd512, 13'd4096, 170);
    no_idle = 1'b1;
    run_random_phase(13'd1024, 13'd8191, 170);
    no_idle = 1'b0;
    run_random_phase(13'd2, 13'd4096, 120);
    run_random_phase(13'($urandom_range(1, 1024)), 13'($urandom_range(1, 4096)), 170);
    run_random_phase(13'd768, 13'd2000, 170);
  endtask

  initial begin
    atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                 256, 128, 64, 32, 16, 8, 4, 2};
    half_pow_coef[1] = int_sqrt(64'd1 << 59);
    for (int b = 2; b <= 24; b++) half_pow_coef[b] = int_sqrt(half_pow_coef[b - 1] << 30);
    width_reg = SPE_MW_RST;
    limit_reg = SPE_MP_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_config_extremes();
    test_random_entries();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/spe_pkg.sv
hdl/spe_div.sv
hdl/spe_exp2.sv
hdl/spe_angle.sv
hdl/spe_cordic.sv
hdl/sinusoidal_position_encoder_unit.sv
bench/sinusoidal_position_encoder_unit_test.sv
